/* src/tmu_pkg.sv */
`default_nettype none

package tmu_pkg;

    // Sizing of the mutex state.
    localparam int CORES       = 16;
    localparam int TICKET_BITS = 8;
    localparam int COUNT_BITS  = 16;

    // Fixed field widths of the request and response beats.
    localparam int ACTION_W = 3;
    localparam int CORE_W   = 4;
    localparam int TKOUT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int MTYPE_W  = 2;

    // The owner register holds any valid core id plus the no-owner code.
    localparam int OWN_W = ($clog2(CORES + 1) > CORE_W) ? $clog2(CORES + 1) : CORE_W;
    // Common width used to move tickets between the counter and the 8-bit fields.
    localparam int TK_W  = (TICKET_BITS > TKOUT_W) ? TICKET_BITS : TKOUT_W;

    localparam logic [OWN_W-1:0] NO_OWNER = OWN_W'(CORES);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT    = 3'd0,
        ACT_LOCK    = 3'd1,
        ACT_TRYLOCK = 3'd2,
        ACT_UNLOCK  = 3'd3,
        ACT_POLL    = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BUSY      = 3'd1,
        ST_DEADLOCK  = 3'd2,
        ST_RETRY     = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_WAITING   = 3'd5
    } t_status;

    typedef enum logic [MTYPE_W-1:0] {
        MT_NORMAL    = 2'd0,
        MT_ERRCHECK  = 2'd1,
        MT_RECURSIVE = 2'd2,
        MT_DEFAULT   = 2'd3
    } t_mtype;

    typedef struct packed {
        logic [OWN_W-1:0]       owner;
        logic [COUNT_BITS-1:0]  count;
        logic [TICKET_BITS-1:0] next_tk;
        logic [TICKET_BITS-1:0] served_tk;
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [TKOUT_W-1:0]   ticket;
        logic                 granted;
    } t_result;

endpackage

`default_nettype wire

/* src/tmu_cfg.sv */
`default_nettype none

module tmu_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [tmu_pkg::MTYPE_W-1:0] o_mutex_type
);
    import tmu_pkg::*;

    logic [MTYPE_W-1:0] r_mutex_type;
    logic               w_wr;

    // Only the lock type register exists, in the word at byte address zero.
    assign w_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mutex_type <= MT_RECURSIVE;
        end else if (w_wr) begin
            r_mutex_type <= pwdata[MTYPE_W-1:0];
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == 1'b0) ? {{(32 - MTYPE_W){1'b0}}, r_mutex_type} : 32'd0;
    assign o_mutex_type = r_mutex_type;

endmodule

`default_nettype wire

/* src/tmu_step.sv */
`default_nettype none

module tmu_step (
    input  wire logic [tmu_pkg::ACTION_W-1:0] i_action,
    input  wire logic [tmu_pkg::CORE_W-1:0]   i_core,
    input  wire logic [tmu_pkg::TKOUT_W-1:0]  i_poll,
    input  wire logic [tmu_pkg::MTYPE_W-1:0]  i_mutex_type,
    input  wire tmu_pkg::t_state              i_state,
    output tmu_pkg::t_state                   o_state,
    output tmu_pkg::t_result                  o_result
);
    import tmu_pkg::*;

    logic [OWN_W-1:0]       w_core;
    logic                   w_core_ok;
    logic                   w_is_owner;
    logic                   w_free;
    logic                   w_recursive;
    logic                   w_cnt_max;
    logic [TK_W-1:0]        w_poll_ext;
    logic [TK_W-1:0]        w_next_ext;
    logic [TICKET_BITS-1:0] w_want;
    logic [TKOUT_W-1:0]     w_next_out;
    t_state                 n_state;
    t_result                n_result;

    assign w_core      = OWN_W'(i_core);
    assign w_core_ok   = (w_core < NO_OWNER);
    assign w_is_owner  = (i_state.owner == w_core);
    assign w_free      = (i_state.owner == NO_OWNER);
    assign w_recursive = (i_mutex_type == MT_RECURSIVE) || (i_mutex_type == MT_DEFAULT);
    assign w_cnt_max   = &i_state.count;
    assign w_poll_ext  = TK_W'(i_poll);
    assign w_next_ext  = TK_W'(i_state.next_tk);
    assign w_want      = w_poll_ext[TICKET_BITS-1:0];
    assign w_next_out  = w_next_ext[TKOUT_W-1:0];

    always_comb begin
        n_state         = i_state;
        n_result.status = ST_OK;
        n_result.ticket = '0;

        if (i_action == ACT_INIT) begin
            n_state.owner     = NO_OWNER;
            n_state.count     = '0;
            n_state.next_tk   = '0;
            n_state.served_tk = '0;
        end else if (!w_core_ok) begin
            n_result.status = ST_NOT_OWNER;
        end else begin
            case (i_action)
                ACT_LOCK, ACT_TRYLOCK: begin
                    if (w_is_owner && (i_mutex_type == MT_ERRCHECK)) begin
                        n_result.status = ST_DEADLOCK;
                    end else if (w_is_owner && w_recursive) begin
                        if (w_cnt_max) begin
                            n_result.status = ST_RETRY;
                        end else begin
                            n_state.count = i_state.count + 1'b1;
                        end
                    end else if (i_action == ACT_LOCK) begin
                        // A normal owner locking again queues behind itself.
                        n_result.ticket = w_next_out;
                        n_state.next_tk = i_state.next_tk + 1'b1;
                        if ((i_state.next_tk == i_state.served_tk) && w_free) begin
                            n_state.owner = w_core;
                        end else begin
                            n_result.status = ST_WAITING;
                        end
                    end else if ((i_state.next_tk == i_state.served_tk) && w_free) begin
                        n_result.ticket = w_next_out;
                        n_state.next_tk = i_state.next_tk + 1'b1;
                        n_state.owner   = w_core;
                    end else begin
                        n_result.status = ST_BUSY;
                    end
                end
                ACT_UNLOCK: begin
                    if (!w_is_owner) begin
                        n_result.status = ST_NOT_OWNER;
                    end else if (i_state.count != '0) begin
                        n_state.count = i_state.count - 1'b1;
                    end else begin
                        n_state.owner     = NO_OWNER;
                        n_state.served_tk = i_state.served_tk + 1'b1;
                    end
                end
                ACT_POLL: begin
                    n_result.ticket = i_poll;
                    if ((w_want == i_state.served_tk) && w_is_owner) begin
                        n_result.status = ST_OK;
                    end else if ((w_want == i_state.served_tk) && w_free &&
                                 (i_state.next_tk != i_state.served_tk)) begin
                        n_state.owner = w_core;
                    end else begin
                        n_result.status = ST_WAITING;
                    end
                end
                default: begin
                    n_result.status = ST_OK;
                end
            endcase
        end

        n_result.granted = (i_action != ACT_INIT) && w_core_ok && (n_state.owner == w_core);
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

`default_nettype wire

/* src/ticket_mutex_unit.sv */
`default_nettype none

// Channel    Dir  Handshake                        Beat contents
// ---------  ---  -------------------------------  ------------------------------------
// request    in   i_s_axis_tvalid/o_s_axis_tready  action, core_id, poll_ticket
// response   out  o_m_axis_tvalid/i_m_axis_tready  status, ticket_out, granted
// config     in   psel/penable/pwrite/pready       mutex_type at byte address 0
//
// Every request beat produces exactly one response beat. A request is held in
// the input register and then moves into the result register, which drives the
// response; one request is taken per cycle while the response side accepts, and
// the single mutex state update sits between the input and result registers.
// Reset (synchronous, active low) empties both registers, frees the mutex,
// zeroes the counters and sets the lock type to recursive.
// When the response side stalls, one request still enters the input register;
// further requests wait until the result register drains.

module ticket_mutex_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request: [2:0] action, [6:3] core_id, [14:7] poll_ticket, [15] zero
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,
    // Response: [2:0] status, [10:3] ticket_out, [11] granted, [15:12] zero
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [15:0] o_m_axis_tdata,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import tmu_pkg::*;

    // Input register holding one accepted request.
    logic                r_in_vld;
    logic [ACTION_W-1:0] r_in_action;
    logic [CORE_W-1:0]   r_in_core;
    logic [TKOUT_W-1:0]  r_in_poll;

    // Mutex state and the result register.
    t_state              r_state;
    t_state              n_state;
    logic                r_out_vld;
    t_result             r_out;
    t_result             n_result;

    logic [MTYPE_W-1:0]  w_mutex_type;
    logic                w_in_acc;
    logic                w_adv;

    tmu_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mutex_type (w_mutex_type)
    );

    // The request moves into the result register whenever that register is
    // empty or being emptied; the state is updated at the same edge, so the
    // requests see the mutex strictly in arrival order.
    assign w_adv           = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    tmu_step u_step (
        .i_action     (r_in_action),
        .i_core       (r_in_core),
        .i_poll       (r_in_poll),
        .i_mutex_type (w_mutex_type),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_action <= i_s_axis_tdata[2:0];
            r_in_core   <= i_s_axis_tdata[6:3];
            r_in_poll   <= i_s_axis_tdata[14:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.owner     <= NO_OWNER;
            r_state.count     <= '0;
            r_state.next_tk   <= '0;
            r_state.served_tk <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {4'd0, r_out.granted, r_out.ticket, r_out.status};

`ifndef SYNTHESIS
    // The owner register only ever holds a core id or the no-owner code.
    a_owner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.owner <= NO_OWNER)
        else $error("owner register out of range");

    // A free mutex never carries a recursion depth.
    a_free_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.owner == NO_OWNER) |-> (r_state.count == '0))
        else $error("recursion count left on a free mutex");

    // A not-owner answer never comes with a grant.
    a_not_owner_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == ST_NOT_OWNER)) |-> !r_out.granted)
        else $error("grant reported with a not-owner status");

    // A request that cannot advance stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("stalled request dropped");
`endif

endmodule

`default_nettype wire

/* verif/ticket_mutex_checker.sv */
`timescale 1ns / 100ps

module ticket_mutex_checker
    import tmu_pkg::*;
#(
    parameter logic [2:0] MTYPE_ADDR = 3'd0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [15:0] i_req_data,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic [15:0] i_rsp_data,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fails,
    output int               o_pending
);

    // Shadow copy of the mutex and of its lock type.
    t_mtype                 lock_kind;
    logic [OWN_W-1:0]       holder;
    logic [COUNT_BITS-1:0]  nest_count;
    logic [TICKET_BITS-1:0] take_tk;
    logic [TICKET_BITS-1:0] serve_tk;

    t_result owed_responses[$];
    int      mismatch_total = 0;

    assign o_fails = mismatch_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic void free_mutex();
        holder     = NO_OWNER;
        nest_count = '0;
        take_tk    = '0;
        serve_tk   = '0;
    endfunction

    // A lock or trylock by the holder. Returns 0 when the lock type lets the
    // request go on as an ordinary lock (normal type).
    function automatic bit holder_relock(output t_status st);
        st = ST_OK;
        if (lock_kind == MT_ERRCHECK) begin
            st = ST_DEADLOCK;
            return 1'b1;
        end
        if (lock_kind == MT_RECURSIVE || lock_kind == MT_DEFAULT) begin
            if (nest_count == '1) begin
                st = ST_RETRY;
            end else begin
                nest_count = nest_count + 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result grant_outcome(input logic [ACTION_W-1:0] act,
                                              input logic [CORE_W-1:0]   core,
                                              input logic [TKOUT_W-1:0]  pt);
        t_result          r;
        t_status          st;
        logic [TKOUT_W-1:0] tk;
        logic [OWN_W-1:0] who;
        bit               mine;
        bit               handled;
        who     = OWN_W'(core);
        st      = ST_OK;
        tk      = '0;
        mine    = (holder == who);
        handled = 1'b0;
        case (act)
            ACT_INIT: begin
                free_mutex();
            end
            ACT_LOCK: begin
                if (mine) handled = holder_relock(st);
                if (!handled) begin
                    tk = TKOUT_W'(take_tk);
                    if (take_tk == serve_tk && holder == NO_OWNER) begin
                        holder = who;
                        st     = ST_OK;
                    end else begin
                        st = ST_WAITING;
                    end
                    take_tk = take_tk + 1'b1;
                end
            end
            ACT_TRYLOCK: begin
                if (mine) handled = holder_relock(st);
                if (!handled) begin
                    if (take_tk == serve_tk && holder == NO_OWNER) begin
                        tk      = TKOUT_W'(take_tk);
                        take_tk = take_tk + 1'b1;
                        holder  = who;
                        st      = ST_OK;
                    end else begin
                        st = ST_BUSY;
                    end
                end
            end
            ACT_UNLOCK: begin
                if (!mine) begin
                    st = ST_NOT_OWNER;
                end else if (nest_count != '0) begin
                    nest_count = nest_count - 1'b1;
                end else begin
                    holder   = NO_OWNER;
                    serve_tk = serve_tk + 1'b1;
                end
            end
            ACT_POLL: begin
                tk = pt;
                if (TICKET_BITS'(pt) == serve_tk && mine) begin
                    st = ST_OK;
                end else if (TICKET_BITS'(pt) == serve_tk && holder == NO_OWNER &&
                             take_tk != serve_tk) begin
                    holder = who;
                    st     = ST_OK;
                end else begin
                    st = ST_WAITING;
                end
            end
            default: begin
                // Spare action codes leave the mutex alone.
            end
        endcase
        r.status  = st;
        r.ticket  = tk;
        r.granted = (act != ACT_INIT) && (holder == who);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            owed_responses.delete();
            lock_kind = MT_RECURSIVE;
            free_mutex();
            o_pending <= 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_responses.size() == 0) begin
                    report_mismatch($sformatf("response beat 0x%04h with nothing outstanding",
                                              i_rsp_data));
                end else begin
                    want = owed_responses.pop_front();
                    if (i_rsp_data[2:0] != want.status || i_rsp_data[10:3] != want.ticket ||
                        i_rsp_data[11] != want.granted || i_rsp_data[15:12] != 4'd0) begin
                        report_mismatch($sformatf(
                            "status %0d exp %0d, ticket %0d exp %0d, granted %0d exp %0d, pad %0h",
                            i_rsp_data[2:0], want.status, i_rsp_data[10:3], want.ticket,
                            i_rsp_data[11], want.granted, i_rsp_data[15:12]));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                owed_responses.push_back(grant_outcome(i_req_data[2:0], i_req_data[6:3],
                                                       i_req_data[14:7]));
            end
            if (i_psel && i_penable && i_pready && i_paddr == MTYPE_ADDR) begin
                if (i_pwrite) begin
                    lock_kind = t_mtype'(i_pwdata[MTYPE_W-1:0]);
                end else if (i_prdata[MTYPE_W-1:0] != lock_kind) begin
                    report_mismatch($sformatf("lock type reads %0d, expected %0d",
                                              i_prdata[MTYPE_W-1:0], lock_kind));
                end
            end
            o_pending <= owed_responses.size();
        end
    end

endmodule

/* verif/ticket_mutex_unit_tb.sv */
`timescale 1ns / 100ps

module ticket_mutex_unit_tb;
    import tmu_pkg::*;

    // Byte address of the lock type register.
    localparam logic [2:0] MTYPE_ADDR = 3'd0;

    // Action codes the block does not define; they must change nothing.
    localparam logic [ACTION_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

    // Trylock/unlock rounds that carry both ticket counters past their wrap.
    localparam int WRAP_ROUNDS = (1 << TICKET_BITS) + 2;
    // Watchdog limit on the length of a run.
    localparam int CYCLE_LIMIT = 40_000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [31:0] prdata;
    wire         pready;

    int fails;
    int pending;

    // Idle odds in percent for each side; changed between phases.
    int src_idle_pct = 36;
    int dst_idle_pct = 70;
    int sent         = 0;
    int cycles       = 0;

    // Rough guess of the next ticket the block will hand out. Well-formed
    // polls aim just below it, where the served counter usually sits.
    logic [TICKET_BITS-1:0] tk_guess = '0;

    always #5 i_clk = ~i_clk;

    ticket_mutex_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // The checker sees every beat on both streams and every register access,
    // keeps its own mutex and reports the failure count back up here.
    ticket_mutex_checker #(.MTYPE_ADDR(MTYPE_ADDR)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_data  (s_tdata),
        .i_rsp_valid (m_tvalid),
        .i_rsp_ready (m_tready),
        .i_rsp_data  (m_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    // The response side stalls at random with the current odds.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one request beat and returns at the edge that accepts it. The
    // valid stays high afterwards so that back-to-back beats need no bubble;
    // a random gap lowers it first.
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [CORE_W-1:0] core,
                            input logic [TKOUT_W-1:0] pt);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pt, core, act};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    // Stops offering beats and waits until every response has come back.
    // The pending count is registered, hence the first wait.
    task automatic drain_responses();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then an idle cycle.
    task automatic apb_access(input logic wr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MTYPE_ADDR;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Changes the lock type and reads it back. Only called with the block idle.
    task automatic set_lock_kind(input t_mtype kind);
        apb_access(1'b1, 32'(kind));
        apb_access(1'b0, '0);
    endtask

    // Random traffic. Most beats come from four cores so that the holder is
    // often the one asking, and most polls carry a ticket close to the served
    // counter so that queued cores really get the mutex. The rest is noise:
    // other cores, tickets anywhere, spare action codes and the odd init.
    task automatic random_phase(input int count);
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [CORE_W-1:0]   core;
        logic [TKOUT_W-1:0]  pt;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            core = ($urandom_range(0, 4) != 0) ? CORE_W'($urandom_range(0, 3))
                                               : CORE_W'($urandom_range(0, 15));
            pt   = TKOUT_W'($urandom);
            if (pick < 2) begin
                act      = ACT_INIT;
                tk_guess = '0;
            end else if (pick < 24) begin
                act      = ACT_LOCK;
                tk_guess = tk_guess + 1'b1;
            end else if (pick < 36) begin
                act = ACT_TRYLOCK;
            end else if (pick < 60) begin
                act = ACT_UNLOCK;
            end else if (pick < 96) begin
                act = ACT_POLL;
                if ($urandom_range(0, 5) != 0) begin
                    pt = TKOUT_W'(tk_guess - TICKET_BITS'($urandom_range(1, 4)));
                end
            end else begin
                act = ACT_SPARE5 + ACTION_W'($urandom_range(0, 2));
            end
            send_req(act, core, pt);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The lock type must come out of reset as recursive.
        apb_access(1'b0, '0);
        set_lock_kind(MT_RECURSIVE);

        // Recursive type: grant, re-locks, a queued core, refusals, release,
        // handover by poll, the holder polling its own ticket, spare codes,
        // a poll with no ticket outstanding, and the field extremes.
        send_req(ACT_INIT,    4'd0,  8'h00);
        send_req(ACT_LOCK,    4'd0,  8'hFF);
        send_req(ACT_LOCK,    4'd0,  8'h00);
        send_req(ACT_TRYLOCK, 4'd0,  8'h00);
        send_req(ACT_LOCK,    4'd15, 8'h00);
        send_req(ACT_TRYLOCK, 4'd5,  8'h00);
        send_req(ACT_UNLOCK,  4'd15, 8'h00);
        send_req(ACT_POLL,    4'd15, 8'h01);
        send_req(ACT_UNLOCK,  4'd0,  8'h00);
        send_req(ACT_UNLOCK,  4'd0,  8'h00);
        send_req(ACT_UNLOCK,  4'd0,  8'h00);
        send_req(ACT_POLL,    4'd15, 8'hFF);
        send_req(ACT_POLL,    4'd15, 8'h01);
        send_req(ACT_POLL,    4'd15, 8'h01);
        send_req(ACT_SPARE5,  4'd15, 8'hAA);
        send_req(ACT_SPARE6,  4'd3,  8'h55);
        send_req(ACT_SPARE7,  4'd15, 8'hFF);
        send_req(ACT_UNLOCK,  4'd15, 8'h00);
        send_req(ACT_POLL,    4'd4,  8'h02);
        send_req(ACT_TRYLOCK, 4'd15, 8'hFF);
        drain_responses();

        // Normal type: the holder locking again queues behind itself for good,
        // and its trylock is refused as busy. After the release its own
        // queued ticket is picked up by a poll.
        set_lock_kind(MT_NORMAL);
        send_req(ACT_LOCK,    4'd15, 8'h00);
        send_req(ACT_TRYLOCK, 4'd15, 8'h00);
        send_req(ACT_UNLOCK,  4'd15, 8'h00);
        send_req(ACT_POLL,    4'd15, 8'h03);
        drain_responses();

        // Error checking type: any re-lock by the holder is a deadlock report.
        set_lock_kind(MT_ERRCHECK);
        send_req(ACT_LOCK,    4'd15, 8'h00);
        send_req(ACT_TRYLOCK, 4'd15, 8'h00);
        send_req(ACT_UNLOCK,  4'd15, 8'h00);
        send_req(ACT_INIT,    4'd0,  8'h00);

        // Take and release the mutex until both counters have wrapped.
        for (int i = 0; i < WRAP_ROUNDS; i++) begin
            send_req(ACT_TRYLOCK, 4'd9, 8'h00);
            send_req(ACT_UNLOCK,  4'd9, 8'h00);
        end
        tk_guess = TICKET_BITS'(WRAP_ROUNDS);
        drain_responses();

        // Random traffic, with the receiver and then the sender idling more.
        set_lock_kind(MT_NORMAL);
        random_phase(55);
        drain_responses();

        src_idle_pct = 70;
        dst_idle_pct = 36;
        set_lock_kind(MT_ERRCHECK);
        random_phase(55);
        drain_responses();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_lock_kind(MT_DEFAULT);
        random_phase(60);
        drain_responses();

        // Leave the lock type at its lowest code once more, then finish.
        set_lock_kind(MT_NORMAL);
        random_phase(10);
        drain_responses();

        $display("Sent %0d request beats under all four lock types, with idle and stall mixes,",
                 sent);
        $display("and carried both ticket counters through their wrap.");
        if (fails == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
